FILE: design/fmt_pkg.sv
// package for the minifloat trimmer: payload structs, register indexes, codes
// no dependencies
`default_nettype none
package fmt_pkg;
  localparam int Fp32Bias = 127;

  typedef struct packed {
    logic [31:0] value_in;
    logic [22:0] random_bits;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  status;
    logic        last_out;
  } out_word_t;

  typedef struct packed {
    logic [4:0] mantissa_bits;
    logic [2:0] exponent_bits;
    logic [1:0] rounding_mode;
  } cfg_t;

  localparam logic [1:0] RegMant = 2'd0;
  localparam logic [1:0] RegExp = 2'd1;
  localparam logic [1:0] RegRound = 2'd2;

  localparam logic [1:0] RndNearest = 2'd0;
  localparam logic [1:0] RndStoch = 2'd1;

  localparam logic [1:0] StNormal = 2'd0;
  localparam logic [1:0] StFlush = 2'd1;
  localparam logic [1:0] StSat = 2'd2;
endpackage
`default_nettype wire

FILE: design/fmt_cfg_regs.sv
// configuration registers of the minifloat trimmer
// uses fmt_pkg
`default_nettype none
module fmt_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output fmt_pkg::cfg_t    cfg
);
  import fmt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mantissa_bits <= 5'd10;
      cfg.exponent_bits <= 3'd5;
      cfg.rounding_mode <= RndNearest;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegMant: cfg.mantissa_bits <= cfg_data[4:0];
        RegExp: cfg.exponent_bits <= cfg_data[2:0];
        RegRound: cfg.rounding_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/fmt_convert.sv
// combinational trim of one fp32 word to the configured minifloat grid
// uses fmt_pkg
`default_nettype none
module fmt_convert (
  input  wire fmt_pkg::cfg_t     cfg,
  input  wire fmt_pkg::in_word_t din,
  output fmt_pkg::out_word_t dout
);
  import fmt_pkg::*;

  logic        sign;
  logic [7:0]  efield;
  logic [22:0] mfield;
  logic [4:0]  m;
  logic [4:0]  s;
  logic [2:0]  eb;
  logic [7:0]  bias;
  logic [7:0]  max_exp;
  logic signed [9:0] mexp;
  logic [23:0] q;
  logic [23:0] one_m;
  logic [45:0] stoch;
  logic [7:0]  ef;
  logic [22:0] mf;

  always_comb begin
    sign = din.value_in[31];
    efield = din.value_in[30:23];
    mfield = din.value_in[22:0];
    m = (cfg.mantissa_bits > 5'd23) ? 5'd23 : cfg.mantissa_bits;
    eb = (cfg.exponent_bits < 3'd2) ? 3'd2 : cfg.exponent_bits;
    s = 5'd23 - m;
    bias = (8'd1 << (eb - 3'd1)) - 8'd1;
    max_exp = (8'd1 << eb) - 8'd1;
    mexp = $signed({2'b00, efield}) - 10'sd127 + $signed({2'b00, bias});
    one_m = 24'd1 << m;
    // stochastic: (mfield*2^m + r) >> 23
    stoch = ({23'd0, mfield} << m) + {23'd0, din.random_bits};
    case (cfg.rounding_mode)
      RndNearest: q = (s == 5'd0) ? {1'b0, mfield}
                      : (({1'b0, mfield} + (24'd1 << (s - 5'd1))) >> s);
      RndStoch: q = {1'b0, stoch[45:23]};
      default: q = {1'b0, mfield} >> s;
    endcase
    ef = 8'd0;
    mf = 23'd0;
    dout.last_out = din.last_in;
    if (efield == 8'd0 || mexp < 10'sd0) begin
      dout.value_out = 32'd0;
      dout.status = StFlush;
    end else if (mexp > $signed({2'b00, max_exp})) begin
      ef = 8'd128 + bias;
      mf = 23'h7FFFFF & ~((23'd1 << s) - 23'd1);
      dout.value_out = {sign, ef, mf};
      dout.status = StSat;
    end else begin
      if (q >= one_m) begin
        ef = efield + 8'd1;
        mf = 23'd0;
      end else begin
        ef = efield;
        mf = q[22:0] << s;
      end
      dout.value_out = {sign, ef, mf};
      dout.status = StNormal;
    end
  end
endmodule
`default_nettype wire

FILE: design/float_to_minifloat_trimmer_core.sv
// top level of the minifloat trimmer: config registers, input and output registers
// uses fmt_pkg, fmt_cfg_regs, fmt_convert
`default_nettype none
// Trims each fp32 word to a minifloat of configurable mantissa and exponent
// width and returns it as fp32 bits. One word per cycle unless stalled; a word
// passes the input register, conversion logic and output register. in_stall
// is high only when both registers are full and out_stall is high. Config
// writes are always taken and should be done while no word is in flight.
module float_to_minifloat_trimmer_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fmt_pkg::in_word_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fmt_pkg::out_word_t out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import fmt_pkg::*;

  cfg_t      cfg;
  in_word_t  in_reg;
  logic      in_reg_valid;
  out_word_t conv;
  logic      adv;

  assign cfg_ready = 1'b1;

  fmt_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  fmt_convert u_conv (.cfg(cfg), .din(in_reg), .dout(conv));

  assign adv = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= in_reg_valid;
      if (!in_stall) in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_reg_valid) out_data <= conv;
    if (!in_stall && in_valid) in_reg <= in_data;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && out_valid && out_stall)
    else $error("input stalled without a full pipe");
  a_move: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !out_stall |=> out_valid)
    else $error("word lost between stages");
endmodule
`default_nettype wire

FILE: sim/tb.sv
// testbench for float_to_minifloat_trimmer_core: directed and random fp32 words
// checked against an in-bench trimming predictor; depends on fmt_pkg and the core
`default_nettype none
module tb;
  import fmt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [4:0] mant_bits;
  logic [2:0] exp_bits;
  logic [1:0] rnd_mode;
  out_word_t trimmed_q[$];
  int errors = 0;
  bit stall_on = 1'b1;
  int hold = 0;

  float_to_minifloat_trimmer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t trim_word(in_word_t w);
    out_word_t r;
    logic [7:0] ef;
    logic [22:0] mf;
    int unsigned m, eb, s, q, efo;
    int bias, max_exp, mexp;
    longint unsigned wide;
    ef = w.value_in[30:23];
    mf = w.value_in[22:0];
    m = (mant_bits > 23) ? 23 : mant_bits;
    eb = (exp_bits < 2) ? 2 : exp_bits;
    s = 23 - m;
    bias = (1 << (eb - 1)) - 1;
    max_exp = (1 << eb) - 1;
    mexp = int'(ef) - Fp32Bias + bias;
    r.last_out = w.last_in;
    if (ef == 0 || mexp < 0) begin
      r.value_out = '0;
      r.status = StFlush;
    end else if (mexp > max_exp) begin
      efo = Fp32Bias + bias + 1;
      r.value_out = {w.value_in[31], efo[7:0], 23'(((1 << m) - 1) << s)};
      r.status = StSat;
    end else begin
      if (rnd_mode == RndNearest) begin
        q = (s == 0) ? mf : ((mf + (1 << (s - 1))) >> s);
      end else if (rnd_mode == RndStoch) begin
        wide = ((longint'(mf) << m) + w.random_bits) >> 23;
        q = int'(wide);
      end else begin
        q = mf >> s;
      end
      efo = ef;
      if (q >= (1 << m)) begin
        efo = ef + 1;
        q = 0;
      end
      r.value_out = {w.value_in[31], efo[7:0], 23'(q << s)};
      r.status = StNormal;
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegMant: mant_bits = val[4:0];
      RegExp: exp_bits = val[2:0];
      RegRound: rnd_mode = val[1:0];
      default: ;
    endcase
  endtask

  // wait for the pipe to drain, then change the format
  task automatic set_format(int m, int e, int rm);
    in_valid <= 1'b0;
    while (trimmed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(RegMant, m);
    write_reg(RegExp, e);
    write_reg(RegRound, rm);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(logic [31:0] v, logic [22:0] r, logic l, int gap);
    in_word_t w;
    w.value_in = v;
    w.random_bits = r;
    w.last_in = l;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trimmed_q.push_back(trim_word(w));
  endtask

  task automatic send_random(int n, bit gaps);
    logic [31:0] v;
    int gap;
    for (int i = 0; i < n; i++) begin
      v = $urandom;
      // keep most exponents near the minifloat range
      if ($urandom_range(0, 3) != 0) v[30:23] = 8'($urandom_range(60, 194));
      gap = gaps ? $urandom_range(0, 16) : 0;
      send_word(v, 23'($urandom), 1'($urandom), gap);
    end
  endtask

  task automatic test_directed;
    send_word(32'h0000_0000, '0, 1'b0, 0);
    send_word(32'h8000_0001, '0, 1'b1, 0);   // denormal
    send_word(32'h7F80_0000, '0, 1'b0, 0);   // infinity
    send_word(32'hFFC0_0001, '1, 1'b1, 0);   // nan
    send_word(32'h7F7F_FFFF, '1, 1'b0, 0);
    send_word(32'h3F80_0000, '0, 1'b0, 0);
    send_word(32'h3F80_1000, '0, 1'b0, 0);   // tie
    send_word(32'h3FFF_FFFF, '0, 1'b0, 0);   // rounding carry
    send_word(32'h477F_F000, '0, 1'b0, 0);   // carry at top exponent
    send_word(32'h4780_0000, '0, 1'b0, 0);   // top exponent, still in range
    send_word(32'h3880_0000, '0, 1'b0, 0);   // one above the lowest kept exponent
    send_word(32'h387F_FFFF, '0, 1'b0, 0);   // lowest kept exponent, rounding carry
  endtask

  task automatic test_formats;
    int m, e, rm;
    set_format(0, 2, RndNearest);
    test_directed();
    set_format(23, 7, RndStoch);
    test_directed();
    send_random(40, 1'b1);
    set_format(31, 0, 3);
    test_directed();
    send_random(40, 1'b1);
    for (int k = 0; k < 12; k++) begin
      m = $urandom_range(0, 31);
      e = $urandom_range(0, 7);
      rm = $urandom_range(0, 3);
      set_format(m, e, rm);
      send_random(72, k % 3 != 0);
    end
  endtask

  task automatic test_stochastic;
    set_format(4, 5, RndStoch);
    for (int i = 0; i < 30; i++) send_word(32'h3F83_0000, 23'($urandom), 1'b0, 0);
    send_word(32'h3F83_0000, '0, 1'b0, 0);
    send_word(32'h3F83_0000, '1, 1'b1, 0);
  endtask

  // after each taken word, hold the output stalled for a drawn number of cycles
  always @(posedge clk) begin
    int n;
    if (rst) begin
      hold <= 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      n = stall_on ? $urandom_range(0, 16) : 0;
      hold <= n;
      out_stall <= (n != 0);
    end else if (hold != 0) begin
      hold <= hold - 1;
      out_stall <= (hold > 1);
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (trimmed_q.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, out_data);
        errors++;
      end else begin
        exp_w = trimmed_q.pop_front();
        if (out_data.value_out !== exp_w.value_out) begin
          $display("%0t value_out: expected %h actual %h", $time, exp_w.value_out,
                   out_data.value_out);
          errors++;
        end
        if (out_data.status !== exp_w.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_w.status,
                   out_data.status);
          errors++;
        end
        if (out_data.last_out !== exp_w.last_out) begin
          $display("%0t last_out: expected %0d actual %0d", $time, exp_w.last_out,
                   out_data.last_out);
          errors++;
        end
      end
    end
  end

  initial begin
    mant_bits = 5'd10;
    exp_bits = 3'd5;
    rnd_mode = RndNearest;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_stochastic();
    test_formats();
    stall_on = 1'b0;
    set_format(10, 5, RndNearest);
    send_random(30, 1'b0);
    stall_on = 1'b1;
    in_valid <= 1'b0;
    while (trimmed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && trimmed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
